[rtl/cstl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cstl_pkg;

   localparam int SLOT_COUNT  = 8;
   localparam int SLOT_W      = $clog2(SLOT_COUNT);

   localparam int CTRL_W      = 7;
   localparam int VALUE_W     = 7;
   localparam int CHAN_W      = 4;
   localparam int TIME_W      = 32;
   localparam int UPD_W       = 32;
   localparam int RSLOT_W     = 3;
   localparam int ACTION_W    = 3;
   localparam int CSR_DATA_W  = 7;
   localparam int CSR_INDEX_W = 1;

   localparam logic [ACTION_W-1:0] ACT_UPDATE   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_FILL     = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_REPLACE  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_EXCLUDED = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_READ     = 3'd4;

   localparam logic MODE_RECORD = 1'b0;
   localparam logic MODE_READ   = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_EXCL_CTRL = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXCL_EN   = 1'b1;

   localparam logic [CTRL_W-1:0] EXCL_CTRL_RESET = 7'd2;
   localparam logic              EXCL_EN_RESET   = 1'b1;

   // lowest field in the lowest bits
   typedef struct packed {
      logic [2:0]          padding;
      logic [RSLOT_W-1:0]  read_slot;
      logic [TIME_W-1:0]   now_ms;
      logic [CHAN_W-1:0]   channel;
      logic [VALUE_W-1:0]  ctrl_value;
      logic [CTRL_W-1:0]   controller;
   } req_data_type;

   typedef struct packed {
      logic [1:0]          padding;
      logic [UPD_W-1:0]    slot_updates;
      logic [TIME_W-1:0]   slot_time;
      logic [CHAN_W-1:0]   slot_channel;
      logic [VALUE_W-1:0]  slot_value;
      logic [CTRL_W-1:0]   slot_controller;
      logic                slot_used;
      logic [RSLOT_W-1:0]  slot;
   } rsp_data_type;

   localparam int REQ_DATA_W = $bits(req_data_type);
   localparam int RSP_DATA_W = $bits(rsp_data_type);

   typedef struct packed {
      logic              load_in;
      logic              scan_en;
      logic              scan_first;
      logic [SLOT_W-1:0] scan_idx;
      logic              finish;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

[rtl/cstl_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module cstl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  cstl_pkg::status_type  status,
   output cstl_pkg::cmd_type     cmd
);
   import cstl_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

   logic [1:0]        state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SCAN;
               idx_in   = '0;
            end
         end
         ST_SCAN: begin
            if (status.is_read || idx_ff == LAST_IDX) begin
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign req_tready     = (state_ff == ST_IDLE);
   assign cmd.load_in    = req_tready && req_tvalid;
   assign cmd.scan_en    = (state_ff == ST_SCAN) && !status.is_read;
   assign cmd.scan_first = (idx_ff == '0);
   assign cmd.scan_idx   = idx_ff;
   assign cmd.finish     = (state_ff == ST_FINISH) && status.out_free;

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> 32'(idx_ff) < SLOT_COUNT)
      else $error("scan index past table");

   a_scan_then_finish: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && idx_ff == LAST_IDX |=> state_ff == ST_FINISH)
      else $error("scan did not end in finish");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && !status.out_free |=> state_ff == ST_FINISH)
      else $error("finish left while output busy");

endmodule

`default_nettype wire

[rtl/cstl_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module cstl_dpath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [cstl_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  logic                                   req_tuser,
   input  logic                                   csr_we,
   input  logic [cstl_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [cstl_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  cstl_pkg::cmd_type                      cmd,
   output cstl_pkg::status_type                   status,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [cstl_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [cstl_pkg::ACTION_W-1:0]          rsp_tuser
);
   import cstl_pkg::*;

   logic [CTRL_W-1:0]   excl_ctrl_ff;
   logic                excl_en_ff;

   req_data_type        in_ff;
   logic                mode_ff;

   logic [SLOT_COUNT-1:0] entry_used_ff;
   logic [CTRL_W-1:0]     entry_controller_ff [SLOT_COUNT];
   logic [VALUE_W-1:0]    entry_value_ff      [SLOT_COUNT];
   logic [CHAN_W-1:0]     entry_channel_ff    [SLOT_COUNT];
   logic [TIME_W-1:0]     entry_time_ff       [SLOT_COUNT];
   logic [UPD_W-1:0]      entry_updates_ff    [SLOT_COUNT];

   logic                hit_ff, hit_in;
   logic [SLOT_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [UPD_W-1:0]    hit_upd_ff, hit_upd_in;
   logic                free_ff, free_in;
   logic [SLOT_W-1:0]   free_idx_ff, free_idx_in;
   logic [SLOT_W-1:0]   best_idx_ff, best_idx_in;
   logic [TIME_W-1:0]   best_age_ff, best_age_in;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_data_type        rsp_data_ff, rsp_data_in;
   logic [ACTION_W-1:0] rsp_action_ff, rsp_action_in;

   logic                hit_prev, free_prev;
   logic [TIME_W-1:0]   scan_age;
   logic                excluded;
   logic [SLOT_W-1:0]   pick_idx;
   logic [UPD_W-1:0]    new_upd;
   logic [SLOT_W-1:0]   rd_idx;
   logic                rd_ok;
   logic                table_we;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         excl_ctrl_ff <= EXCL_CTRL_RESET;
         excl_en_ff   <= EXCL_EN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_EXCL_CTRL: excl_ctrl_ff <= csr_wdata;
            CSR_EXCL_EN:   excl_en_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // input word
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_ff   <= req_data_type'(req_tdata);
         mode_ff <= req_tuser;
      end
   end

   assign status.is_read  = (mode_ff == MODE_READ);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   // scan step: one slot per cycle
   assign hit_prev  = cmd.scan_first ? 1'b0 : hit_ff;
   assign free_prev = cmd.scan_first ? 1'b0 : free_ff;
   assign scan_age  = in_ff.now_ms - entry_time_ff[cmd.scan_idx];

   always_comb begin
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_upd_in  = hit_upd_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      best_idx_in = best_idx_ff;
      best_age_in = best_age_ff;
      if (cmd.scan_en) begin
         hit_in  = hit_prev;
         free_in = free_prev;
         if (!hit_prev && entry_used_ff[cmd.scan_idx]
             && entry_controller_ff[cmd.scan_idx] == in_ff.controller) begin
            hit_in     = 1'b1;
            hit_idx_in = cmd.scan_idx;
            hit_upd_in = entry_updates_ff[cmd.scan_idx];
         end
         if (!free_prev && !entry_used_ff[cmd.scan_idx]) begin
            free_in     = 1'b1;
            free_idx_in = cmd.scan_idx;
         end
         if (cmd.scan_first || scan_age > best_age_ff) begin
            best_idx_in = cmd.scan_idx;
            best_age_in = scan_age;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         hit_ff  <= hit_in;
         free_ff <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff  <= hit_idx_in;
      hit_upd_ff  <= hit_upd_in;
      free_idx_ff <= free_idx_in;
      best_idx_ff <= best_idx_in;
      best_age_ff <= best_age_in;
   end

   // decision and result
   assign excluded = excl_en_ff && (in_ff.controller == excl_ctrl_ff);
   assign pick_idx = hit_ff ? hit_idx_ff : (free_ff ? free_idx_ff : best_idx_ff);
   assign new_upd  = hit_ff ? hit_upd_ff + UPD_W'(1) : UPD_W'(1);
   assign rd_idx   = SLOT_W'(in_ff.read_slot);
   assign rd_ok    = (32'(in_ff.read_slot) < SLOT_COUNT) && entry_used_ff[rd_idx];
   assign table_we = cmd.finish && !status.is_read && !excluded;

   always_comb begin
      rsp_data_in   = '0;
      rsp_action_in = ACT_EXCLUDED;
      if (status.is_read) begin
         rsp_action_in    = ACT_READ;
         rsp_data_in.slot = in_ff.read_slot;
         if (rd_ok) begin
            rsp_data_in.slot_used       = 1'b1;
            rsp_data_in.slot_controller = entry_controller_ff[rd_idx];
            rsp_data_in.slot_value      = entry_value_ff[rd_idx];
            rsp_data_in.slot_channel    = entry_channel_ff[rd_idx];
            rsp_data_in.slot_time       = entry_time_ff[rd_idx];
            rsp_data_in.slot_updates    = entry_updates_ff[rd_idx];
         end
      end else if (!excluded) begin
         if (hit_ff) begin
            rsp_action_in = ACT_UPDATE;
         end else if (free_ff) begin
            rsp_action_in = ACT_FILL;
         end else begin
            rsp_action_in = ACT_REPLACE;
         end
         rsp_data_in.slot            = RSLOT_W'(pick_idx);
         rsp_data_in.slot_used       = 1'b1;
         rsp_data_in.slot_controller = in_ff.controller;
         rsp_data_in.slot_value      = in_ff.ctrl_value;
         rsp_data_in.slot_channel    = in_ff.channel;
         rsp_data_in.slot_time       = in_ff.now_ms;
         rsp_data_in.slot_updates    = new_upd;
      end
   end

   // slot table
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_used_ff <= '0;
      end else if (table_we) begin
         entry_used_ff[pick_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (table_we) begin
         entry_controller_ff[pick_idx] <= in_ff.controller;
         entry_value_ff[pick_idx]      <= in_ff.ctrl_value;
         entry_channel_ff[pick_idx]    <= in_ff.channel;
         entry_time_ff[pick_idx]       <= in_ff.now_ms;
         entry_updates_ff[pick_idx]    <= new_upd;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_action_ff <= rsp_action_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_action_ff;

   a_replace_when_full: assert property (@(posedge clock) disable iff (reset)
      table_we && !hit_ff && !free_ff |-> &entry_used_ff)
      else $error("replacement with a free slot left");

   a_hit_matches: assert property (@(posedge clock) disable iff (reset)
      table_we && hit_ff |->
         entry_used_ff[hit_idx_ff] && entry_controller_ff[hit_idx_ff] == in_ff.controller)
      else $error("update hit on a slot of another controller");

   a_record_shows_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_action_ff == ACT_UPDATE || rsp_action_ff == ACT_FILL
         || rsp_action_ff == ACT_REPLACE) |-> rsp_data_ff.slot_used)
      else $error("recorded slot shown unused");

endmodule

`default_nettype wire

[rtl/controller_slot_table_lru_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Controller slot table with least-recently-updated replacement. A record word
// (tuser 0) looks up its controller number among SLOT_COUNT slots by a serial
// scan, one slot per cycle, then updates the matching slot, fills the lowest
// free one, or replaces the slot with the greatest wrapping age; a read word
// (tuser 1) returns one slot unchanged. The configured excluded controller is
// answered with action 3 and leaves the table alone. A record word always scans
// every slot before its result goes to the output register; a read word skips
// the scan. A new word is taken once the previous one has moved into the output
// register, even while it waits there.
module controller_slot_table_lru_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // controller, ctrl_value, channel, now_ms, read_slot, zero pad
   input  logic [cstl_pkg::REQ_DATA_W-1:0]     req_tdata,
   // mode
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // slot, slot_used, slot_controller, slot_value, slot_channel, slot_time,
   // slot_updates, zero pad
   output logic [cstl_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // action
   output logic [cstl_pkg::ACTION_W-1:0]       rsp_tuser,
   input  logic                                csr_we,
   input  logic [cstl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cstl_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import cstl_pkg::*;

   cmd_type    cmd;
   status_type status;

   cstl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cstl_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
